// File: hw/rtl/spgf_pkg.sv
package spgf_pkg;

    // fixed width of every value field on the ports
    localparam int VALUE_BITS = 31;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [1:0]            t_status;

    // result status codes
    localparam t_status ST_NONE    = 2'd0;
    localparam t_status ST_PAIR    = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

endpackage

// File: hw/rtl/spgf_ram.sv
module spgf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/spgf_rem.sv
module spgf_rem #(
    parameter int SW = 18
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  spgf_pkg::t_value    i_dividend,
    input  logic [SW-1:0]       i_divisor,
    output logic                o_done,
    output logic [SW-1:0]       o_rem
);

    localparam int DW = spgf_pkg::VALUE_BITS;
    localparam int CNW = $clog2(DW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_div;
    logic [SW-1:0]  r_dv;
    logic [SW-1:0]  r_rem;
    logic [SW:0]    trial;
    logic [SW:0]    diff;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_div[DW-1]};
        diff  = trial - {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_dv  <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[DW-2:0], 1'b0};
            if (trial >= {1'b0, r_dv}) begin
                r_rem <= diff[SW-1:0];
            end else begin
                r_rem <= trial[SW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/segmented_prime_gap_finder_unit.sv
// Segmented prime gap finder.
// Input channel: i_in_valid / o_in_stall carry one request (low and high
// bound). Output channel: o_out_valid / i_out_stall carry one result
// (status plus closest and farthest adjacent prime pair) per request.
// After reset the block fills and sieves its base prime table; o_in_stall
// is high meanwhile.
// A request then presets the window memory, checks each base prime
// candidate p with p*p <= high, has the shared remainder unit compute low
// mod p for each base prime (one bit a cycle), crosses out the multiples
// of p in the window, and scans the window for adjacent primes.
// The window memory ports (one write, one read) bound the preset, the
// crossing-out and the scan.
// An empty or oversized range returns status invalid without a sieve.
// Only one request is in flight; o_in_stall stays high until the result has
// been taken. The result holds stable while i_out_stall is high.
module segmented_prime_gap_finder_unit #(
    parameter int BASE_LIMIT     = 65536,
    parameter int WINDOW_ENTRIES = 1048576
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  spgf_pkg::t_value     i_low_bound,
    input  spgf_pkg::t_value     i_high_bound,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output spgf_pkg::t_status    o_status,
    output spgf_pkg::t_value     o_closest_first,
    output spgf_pkg::t_value     o_closest_second,
    output spgf_pkg::t_value     o_farthest_first,
    output spgf_pkg::t_value     o_farthest_second
);

    localparam int SA  = $clog2(BASE_LIMIT + 1);
    localparam int PW  = SA + 1;
    localparam int PPW = 2 * PW;
    localparam int CW  = (PPW > 34) ? PPW : 34;
    localparam int WA  = $clog2(WINDOW_ENTRIES);
    localparam int SPW = WA + 1;
    localparam int VB  = spgf_pkg::VALUE_BITS;

    // sequencer states
    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_BSQ   = 4'd1;
    localparam logic [3:0] S_BCHK  = 4'd2;
    localparam logic [3:0] S_BMARK = 4'd3;
    localparam logic [3:0] S_IDLE  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_FILL  = 4'd6;
    localparam logic [3:0] S_QSQ   = 4'd7;
    localparam logic [3:0] S_QCHK  = 4'd8;
    localparam logic [3:0] S_QREM  = 4'd9;
    localparam logic [3:0] S_QMARK = 4'd10;
    localparam logic [3:0] S_SCAN  = 4'd11;
    localparam logic [3:0] S_SDRN  = 4'd12;
    localparam logic [3:0] S_RES   = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]          r_state;
    spgf_pkg::t_value    r_lo, r_hi;
    logic [SPW-1:0]      r_span;
    logic [WA-1:0]       r_i;
    logic [PW-1:0]       r_p;
    logic [PPW-1:0]      r_pp;
    logic [CW-1:0]       r_m;
    logic                r_pend;
    spgf_pkg::t_value    r_pv, r_prev;
    logic [1:0]          r_cnt;
    spgf_pkg::t_value    r_min, r_max;
    spgf_pkg::t_value    r_cf, r_cs, r_ff, r_fs;
    spgf_pkg::t_status   r_status;

    logic [31:0]         span32;
    logic                bad_range;
    logic [31:0]         fill_val;
    logic [CW-1:0]       start_v;
    logic                rem_start, rem_done;
    logic [PW-1:0]       rem_val;
    logic                sm_we, sm_wd, sm_rd;
    logic                sg_we, sg_wd, sg_rd;
    logic [WA-1:0]       sg_wa;
    logic [CW-1:0]       mark_off;
    spgf_pkg::t_value    gap;
    logic                take;

    // range checks
    always_comb begin
        span32    = {1'b0, r_hi} - {1'b0, r_lo} + 32'd1;
        bad_range = (r_hi < r_lo) || (span32 > 32'(WINDOW_ENTRIES));
        fill_val  = {1'b0, r_lo} + 32'(r_i);
        mark_off  = r_m - CW'(r_lo);
        // first multiple of p at or above low, raised to p*p if it lies below
        start_v   = CW'(r_lo) + ((rem_val == '0) ? CW'(0) : (CW'(r_p) - CW'(rem_val)));
        if (start_v < CW'(r_pp)) begin
            start_v = CW'(r_pp);
        end
        gap  = r_pv - r_prev;
        take = r_pend && sg_rd && (r_state == S_SCAN || r_state == S_SDRN);
    end

    // base table write port
    always_comb begin
        sm_we = (r_state == S_INIT) ||
                ((r_state == S_BMARK) && (r_m <= CW'(BASE_LIMIT)));
        sm_wd = (r_state == S_INIT) && (r_m >= CW'(2));
    end

    // window write port
    always_comb begin
        sg_we = (r_state == S_FILL) ||
                ((r_state == S_QMARK) && (r_m <= CW'(r_hi)));
        sg_wa = (r_state == S_FILL) ? r_i : mark_off[WA-1:0];
        sg_wd = (r_state == S_FILL) && (fill_val >= 32'd2);
    end

    assign rem_start = (r_state == S_QCHK) && !(r_p > PW'(BASE_LIMIT)) &&
                       !(CW'(r_pp) > CW'(r_hi)) && sm_rd;

    spgf_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT + 1)) u_base_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sm_we),
        .i_wr_addr (r_m[SA-1:0]),
        .i_wr_data (sm_wd),
        .i_rd_addr (r_p[SA-1:0]),
        .o_rd_data (sm_rd)
    );

    spgf_ram #(.WIDTH(1), .DEPTH(WINDOW_ENTRIES)) u_seg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (sg_we),
        .i_wr_addr (sg_wa),
        .i_wr_data (sg_wd),
        .i_rd_addr (r_i),
        .o_rd_data (sg_rd)
    );

    spgf_rem #(.SW(PW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_lo),
        .i_divisor  (r_p),
        .o_done     (rem_done),
        .o_rem      (rem_val)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_m     <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            case (r_state)
                S_INIT: begin
                    if (r_m == CW'(BASE_LIMIT)) begin
                        r_p     <= PW'(2);
                        r_state <= S_BSQ;
                    end else begin
                        r_m <= r_m + 1'b1;
                    end
                end
                S_BSQ: begin
                    r_pp    <= PPW'(r_p) * PPW'(r_p);
                    r_state <= S_BCHK;
                end
                S_BCHK: begin
                    if (CW'(r_pp) > CW'(BASE_LIMIT)) begin
                        r_state <= S_IDLE;
                    end else if (sm_rd) begin
                        r_m     <= CW'(r_pp);
                        r_state <= S_BMARK;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_BSQ;
                    end
                end
                S_BMARK: begin
                    if (r_m > CW'(BASE_LIMIT)) begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_BSQ;
                    end else begin
                        r_m <= r_m + CW'(r_p);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_lo    <= i_low_bound;
                        r_hi    <= i_high_bound;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cf <= '0;
                    r_cs <= '0;
                    r_ff <= '0;
                    r_fs <= '0;
                    if (bad_range) begin
                        r_status <= spgf_pkg::ST_INVALID;
                        r_state  <= S_OUT;
                    end else begin
                        r_span  <= span32[SPW-1:0];
                        r_i     <= '0;
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (SPW'(r_i) == r_span - 1'b1) begin
                        r_p     <= PW'(2);
                        r_state <= S_QSQ;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_QSQ: begin
                    r_pp    <= PPW'(r_p) * PPW'(r_p);
                    r_state <= S_QCHK;
                end
                S_QCHK: begin
                    if ((r_p > PW'(BASE_LIMIT)) || (CW'(r_pp) > CW'(r_hi))) begin
                        r_i     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end else if (sm_rd) begin
                        r_state <= S_QREM;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_QSQ;
                    end
                end
                S_QREM: begin
                    if (rem_done) begin
                        r_m     <= start_v;
                        r_state <= S_QMARK;
                    end
                end
                S_QMARK: begin
                    if (r_m > CW'(r_hi)) begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_QSQ;
                    end else begin
                        r_m <= r_m + CW'(r_p);
                    end
                end
                S_SCAN: begin
                    r_pend <= 1'b1;
                    r_pv   <= fill_val[VB-1:0];
                    if (SPW'(r_i) == r_span - 1'b1) begin
                        r_state <= S_SDRN;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SDRN: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (r_cnt == 2'd2) begin
                        r_status <= spgf_pkg::ST_PAIR;
                    end else begin
                        r_status <= spgf_pkg::ST_NONE;
                        r_cf     <= '0;
                        r_cs     <= '0;
                        r_ff     <= '0;
                        r_fs     <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // gap tracking on each prime seen during the scan
            if (take) begin
                if (r_cnt != 2'd0) begin
                    if (r_cnt == 2'd1 || gap < r_min) begin
                        r_min <= gap;
                        r_cf  <= r_prev;
                        r_cs  <= r_pv;
                    end
                    if (r_cnt == 2'd1 || gap > r_max) begin
                        r_max <= gap;
                        r_ff  <= r_prev;
                        r_fs  <= r_pv;
                    end
                end
                r_prev <= r_pv;
                if (r_cnt != 2'd2) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_status          = r_status;
    assign o_closest_first   = r_cf;
    assign o_closest_second  = r_cs;
    assign o_farthest_first  = r_ff;
    assign o_farthest_second = r_fs;

endmodule

// File: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  BASE_LIMIT     = 65536;
    localparam int  WINDOW_ENTRIES = 1048576;
    localparam longint VALUE_MAX   = 64'h7FFF_FFFF;

    typedef struct {
        spgf_pkg::t_value lo;
        spgf_pkg::t_value hi;
        int               send_idle_pct;
        int               recv_stall_pct;
        bit               drain_first;
    } t_range_req;

    typedef struct {
        spgf_pkg::t_status status;
        spgf_pkg::t_value  c1;
        spgf_pkg::t_value  c2;
        spgf_pkg::t_value  f1;
        spgf_pkg::t_value  f2;
    } t_gap_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    spgf_pkg::t_value  i_low_bound = '0;
    spgf_pkg::t_value  i_high_bound = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    spgf_pkg::t_status o_status;
    spgf_pkg::t_value  o_closest_first;
    spgf_pkg::t_value  o_closest_second;
    spgf_pkg::t_value  o_farthest_first;
    spgf_pkg::t_value  o_farthest_second;

    t_range_req  pending_reqs[$];
    t_gap_result expected_gaps[$];
    bit          base_prime[0:BASE_LIMIT];
    int          recv_stall_pct = 0;
    int          mismatches = 0;

    segmented_prime_gap_finder_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // small prime table, same as the one the block builds after reset
    function automatic void build_base_primes();
        for (int k = 0; k <= BASE_LIMIT; k++) base_prime[k] = (k >= 2);
        for (int p = 2; p * p <= BASE_LIMIT; p++) begin
            if (base_prime[p]) begin
                for (int m = p * p; m <= BASE_LIMIT; m += p) base_prime[m] = 0;
            end
        end
    endfunction

    // sieve the window and find the closest and farthest adjacent primes
    function automatic t_gap_result predict_gaps(spgf_pkg::t_value lo_v,
                                                 spgf_pkg::t_value hi_v);
        t_gap_result r;
        longint lo;
        longint hi;
        longint span;
        longint start;
        longint prev;
        longint gap;
        longint min_gap;
        longint max_gap;
        longint count;
        bit     seg[];
        lo = lo_v;
        hi = hi_v;
        r = '{spgf_pkg::ST_NONE, '0, '0, '0, '0};
        if (hi < lo || hi - lo + 1 > WINDOW_ENTRIES) begin
            r.status = spgf_pkg::ST_INVALID;
            return r;
        end
        span = hi - lo + 1;
        seg = new[span];
        for (longint i = 0; i < span; i++) seg[i] = (lo + i >= 2);
        for (longint p = 2; p <= BASE_LIMIT && p * p <= hi; p++) begin
            if (!base_prime[p]) continue;
            start = ((lo + p - 1) / p) * p;
            if (start < p * p) start = p * p;
            for (longint m = start; m <= hi; m += p) seg[m - lo] = 0;
        end
        count = 0;
        prev = 0;
        min_gap = 0;
        max_gap = 0;
        for (longint i = 0; i < span; i++) begin
            if (!seg[i]) continue;
            if (count > 0) begin
                gap = lo + i - prev;
                if (count == 1 || gap < min_gap) begin
                    min_gap = gap;
                    r.c1 = spgf_pkg::t_value'(prev);
                    r.c2 = spgf_pkg::t_value'(lo + i);
                end
                if (count == 1 || gap > max_gap) begin
                    max_gap = gap;
                    r.f1 = spgf_pkg::t_value'(prev);
                    r.f2 = spgf_pkg::t_value'(lo + i);
                end
            end
            prev = lo + i;
            count++;
        end
        if (count < 2) begin
            r = '{spgf_pkg::ST_NONE, '0, '0, '0, '0};
        end else begin
            r.status = spgf_pkg::ST_PAIR;
        end
        return r;
    endfunction

    function automatic void add_req(longint lo, longint hi, int s_pct, int r_pct,
                                    bit drain = 1'b0);
        t_range_req q;
        q.lo = spgf_pkg::t_value'(lo);
        q.hi = spgf_pkg::t_value'(hi);
        q.send_idle_pct = s_pct;
        q.recv_stall_pct = r_pct;
        q.drain_first = drain;
        pending_reqs.push_back(q);
    endfunction

    // one random request, mostly small well-formed windows
    function automatic void add_random_req(int s_pct, int r_pct, bit drain);
        int     kind;
        longint a;
        longint b;
        kind = $urandom_range(99);
        if (kind < 65) begin
            b = $urandom_range(200000, 2);
            a = b - $urandom_range(300, 0);
            if (a < 1) a = 1;
        end else if (kind < 75) begin
            a = $urandom_range(200000, 1);
            b = a + $urandom_range(2, 0);
        end else if (kind < 90) begin
            a = $urandom & VALUE_MAX;
            b = $urandom & VALUE_MAX;
            if (a == b) b = a ^ 1;
            if (b > a) begin
                gap_swap: begin
                    longint t;
                    t = a;
                    a = b;
                    b = t;
                end
            end
        end else begin
            a = $urandom_range(1000000, 1);
            b = a + WINDOW_ENTRIES + $urandom_range(1000000, 0);
        end
        add_req(a, b, s_pct, r_pct, drain);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) expected_gaps.push_back(predict_gaps(i_low_bound, i_high_bound));
            if (pending_reqs.size() != 0
                    && !(pending_reqs[0].drain_first
                         && (i_in_valid || expected_gaps.size() != 0))
                    && $urandom_range(99) >= pending_reqs[0].send_idle_pct) begin
                t_range_req q;
                q = pending_reqs.pop_front();
                recv_stall_pct <= q.recv_stall_pct;
                i_low_bound <= q.lo;
                i_high_bound <= q.hi;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_gaps.size() == 0) begin
                    $error("unexpected result, status %0d", o_status);
                    mismatches++;
                end else begin
                    t_gap_result e;
                    e = expected_gaps.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        mismatches++;
                    end
                    if (o_closest_first !== e.c1) begin
                        $error("closest_first exp %0d got %0d", e.c1, o_closest_first);
                        mismatches++;
                    end
                    if (o_closest_second !== e.c2) begin
                        $error("closest_second exp %0d got %0d", e.c2, o_closest_second);
                        mismatches++;
                    end
                    if (o_farthest_first !== e.f1) begin
                        $error("farthest_first exp %0d got %0d", e.f1, o_farthest_first);
                        mismatches++;
                    end
                    if (o_farthest_second !== e.f2) begin
                        $error("farthest_second exp %0d got %0d", e.f2, o_farthest_second);
                        mismatches++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // directed and random stimulus, then the end of run
    initial begin
        build_base_primes();
        add_req(1, 1, 0, 0);                        // one, not prime
        add_req(1, 2, 0, 0);                        // single prime
        add_req(2, 3, 0, 0);                        // exactly two primes
        add_req(1, 100, 0, 0);
        add_req(1, 3, 0, 0);
        add_req(90, 96, 0, 0);                      // no primes
        add_req(24, 30, 0, 0);
        add_req(5, 4, 0, 0);                        // empty range
        add_req(VALUE_MAX, 1, 0, 0);                // empty, extreme bounds
        add_req(1, VALUE_MAX, 0, 0);                // oversized
        add_req(1, WINDOW_ENTRIES + 1, 0, 0);       // one past the window
        add_req(1000, 1000 + WINDOW_ENTRIES, 0, 0);
        add_req(VALUE_MAX - 47, VALUE_MAX, 0, 0);   // top of the value range
        add_req(65521, 65600, 0, 0);                // around the base limit
        add_req(113, 127, 0, 0);                    // wide gap
        add_req(1, 30, 0, 0, 1'b1);                 // wait for all results first
        for (int k = 0; k < 100; k++) begin
            case (k / 25)
                0: add_random_req(0, 0, k == 10);
                1: add_random_req(88, 0, 1'b0);
                2: add_random_req(0, 88, 1'b0);
                default: add_random_req(23, 23, 1'b0);
            endcase
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !i_in_valid && expected_gaps.size() == 0);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_gaps.size() == 0) begin
            $display("segmented_prime_gap_finder_unit: match");
        end else begin
            $display("segmented_prime_gap_finder_unit: mismatch");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60000000;
        $display("segmented_prime_gap_finder_unit: mismatch");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/spgf_pkg.sv
hw/rtl/spgf_ram.sv
hw/rtl/spgf_rem.sv
hw/rtl/segmented_prime_gap_finder_unit.sv
dv/tb_top.sv
